FILE: design/color_key_sprite_blitter_unit_assert.svh
// assertion macros shared by the checker
`ifndef COLOR_KEY_SPRITE_BLITTER_UNIT_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLITTER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CKB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ckb_pkg.sv
`default_nettype none
package ckb_pkg;

   // frame store geometry, both sizes powers of two
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 256;
   localparam int PIXEL_BITS  = 32;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   // op queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // request codes
   localparam logic [1:0] REQ_HEADER = 2'd0;
   localparam logic [1:0] REQ_PIXEL  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // register indexes and reset values
   localparam logic       CSR_FRAME_WIDTH    = 1'b0;
   localparam logic       CSR_FRAME_HEIGHT   = 1'b1;
   localparam logic [9:0] FRAME_WIDTH_RESET  = 10'd320;
   localparam logic [8:0] FRAME_HEIGHT_RESET = 9'd224;

   localparam logic [PIXEL_BITS-1:0] COLOR_KEY = '0;

   typedef logic [1:0] op_kind_type;
   localparam op_kind_type OP_WRITE = 2'd0;
   localparam op_kind_type OP_READ  = 2'd1;
   localparam op_kind_type OP_CLEAR = 2'd2;

   typedef struct packed {
      op_kind_type           kind;
      logic [ADDR_BITS-1:0]  addr;
      logic [PIXEL_BITS-1:0] color;
      logic                  outside;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: design/ckb_front.sv
`default_nettype none
module ckb_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [1:0]           req_type,
   input  wire logic signed [11:0]   req_pos_x,
   input  wire logic signed [11:0]   req_pos_y,
   input  wire logic [9:0]           req_sprite_width,
   input  wire logic [9:0]           req_sprite_height,
   input  wire logic [31:0]          req_pixel_color,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [9:0]           csr_data,
   output logic                      push,
   output ckb_pkg::op_type           push_op
);
   import ckb_pkg::*;

   logic [9:0]  frame_width_ff, frame_width_in;
   logic [8:0]  frame_height_ff, frame_height_in;
   logic [11:0] origin_x_ff, origin_x_in;
   logic [11:0] origin_y_ff, origin_y_in;
   logic [9:0]  cur_width_ff, cur_width_in;
   logic [9:0]  cur_height_ff, cur_height_in;
   logic [9:0]  column_count_ff, column_count_in;
   logic [9:0]  row_count_ff, row_count_in;

   logic [11:0]           vis_w, vis_h;
   logic [12:0]           px, py, rx, ry;
   logic                  pix_live, pix_vis, rd_vis;
   logic [10:0]           col_next;
   logic [PIXEL_BITS-1:0] color;

   function automatic logic in_frame(input logic [12:0] x, input logic [12:0] y,
                                     input logic [11:0] w, input logic [11:0] h);
      return !x[12] && !y[12] && (x[11:0] < w) && (y[11:0] < h);
   endfunction

   // visible size, clamped to the store
   assign vis_w = (12'(frame_width_ff) > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH)
                                                         : 12'(frame_width_ff);
   assign vis_h = (12'(frame_height_ff) > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT)
                                                           : 12'(frame_height_ff);

   // pixel position from origin plus counters
   assign px       = {origin_x_ff[11], origin_x_ff} + {3'b000, column_count_ff};
   assign py       = {origin_y_ff[11], origin_y_ff} + {3'b000, row_count_ff};
   assign rx       = {req_pos_x[11], req_pos_x};
   assign ry       = {req_pos_y[11], req_pos_y};
   assign color    = req_pixel_color[PIXEL_BITS-1:0];
   assign pix_live = (cur_width_ff != 10'd0) && (cur_height_ff != 10'd0)
                     && (row_count_ff < cur_height_ff);
   assign pix_vis  = in_frame(px, py, vis_w, vis_h) && (color != COLOR_KEY);
   assign rd_vis   = in_frame(rx, ry, vis_w, vis_h);
   assign col_next = {1'b0, column_count_ff} + 11'd1;

   // classify the request into a back-end op
   always_comb begin
      push            = 1'b0;
      push_op.kind    = OP_WRITE;
      push_op.addr    = {py[ROW_BITS-1:0], px[COL_BITS-1:0]};
      push_op.color   = color;
      push_op.outside = 1'b0;
      case (req_type)
         REQ_PIXEL: begin
            push = accept && pix_live && pix_vis;
         end
         REQ_READ: begin
            push            = accept;
            push_op.kind    = OP_READ;
            push_op.addr    = {ry[ROW_BITS-1:0], rx[COL_BITS-1:0]};
            push_op.outside = !rd_vis;
         end
         REQ_CLEAR: begin
            push         = accept;
            push_op.kind = OP_CLEAR;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // sprite state and counters
   always_comb begin
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      cur_width_in    = cur_width_ff;
      cur_height_in   = cur_height_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept && req_type == REQ_HEADER) begin
         origin_x_in     = req_pos_x;
         origin_y_in     = req_pos_y;
         cur_width_in    = req_sprite_width;
         cur_height_in   = req_sprite_height;
         column_count_in = '0;
         row_count_in    = '0;
      end else if (accept && req_type == REQ_PIXEL && pix_live) begin
         if (col_next >= {1'b0, cur_width_ff}) begin
            column_count_in = '0;
            row_count_in    = row_count_ff + 10'd1;
         end else begin
            column_count_in = col_next[9:0];
         end
      end
   end

   // frame size registers
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data[8:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         cur_width_ff    <= '0;
         cur_height_ff   <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         cur_width_ff    <= cur_width_in;
         cur_height_ff   <= cur_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/ckb_queue.sv
`default_nettype none
module ckb_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ckb_pkg::op_type      push_op,
   input  wire logic                 pop,
   output ckb_pkg::op_type           head_op,
   output ckb_pkg::queue_status_type status
);
   import ckb_pkg::*;

   op_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign head_op      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

FILE: design/ckb_back.sv
`default_nettype none
module ckb_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ckb_pkg::op_type head_op,
   input  wire logic            head_valid,
   input  wire logic            csr_we,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_read_color,
   output logic                 rsp_read_outside
);
   import ckb_pkg::*;

   logic [PIXEL_BITS-1:0] store [STORE_DEPTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  rd_outside_ff;
   logic                  clr_active_ff, clr_active_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [PIXEL_BITS-1:0] wr_data;
   logic                  rd_en;

   assign pop      = head_valid && !clr_active_ff;
   assign clearing = clr_active_ff;
   assign rd_en    = pop && (head_op.kind == OP_READ) && !head_op.outside;

   // write port: clearing sweep or pixel write
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = head_op.addr;
      wr_data = head_op.color;
      if (clr_active_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (pop && head_op.kind == OP_WRITE) begin
         wr_en = 1'b1;
      end
   end

   // clearing sweep control
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (csr_we) begin
         clr_active_in = 1'b1;
         clr_addr_in   = '0;
      end else if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_BITS'(STORE_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end else if (pop && head_op.kind == OP_CLEAR) begin
         clr_active_in = 1'b1;
         clr_addr_in   = '0;
      end
   end

   assign rd_valid_in = pop && (head_op.kind == OP_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store[head_op.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_outside_ff <= head_op.outside;
      end
   end

   // read result
   assign rsp_valid        = rd_valid_ff;
   assign rsp_read_outside = rd_outside_ff;
   assign rsp_read_color   = rd_outside_ff ? 32'd0 : 32'(rd_data_ff);

endmodule
`default_nettype wire

FILE: design/color_key_sprite_blitter_unit.sv
// Sprite blitter with colour key over a 512 x 256 frame store of 32-bit pixels.
// Request channel: start/busy; a request is taken on a rising edge with start
// high and busy low. req_type selects sprite header, source pixel, frame read
// or frame clear. Headers set origin and size; source pixels follow in
// row-major order, clipped to the frame and skipped when the colour is 0.
// A front stage classifies requests and queues ops; a back stage runs them on
// the frame store, one op per cycle unless clearing, so one request is taken
// every cycle while the op queue has room, no sweep runs and csr_valid is low.
// Result channel: a frame read returns rsp_read_color / rsp_read_outside with
// rsp_valid high for one cycle, after the op has passed the op queue and the
// read register, behind any ops queued ahead of it. The receiver cannot stall.
// Clear request and any register write sweep the whole store at one word a
// cycle, all 131072 words, with busy high while the sweep runs.
// Register channel: csr_valid/csr_ready, index 0 frame width, 1 frame height;
// csr_ready is high once all queued ops have gone to the store, and busy is
// held high while csr_valid waits so no request goes in beside the write.
// Reset (synchronous) restores the default 320 x 224 frame, clears sprite
// state and starts the sweep that clears all 131072 words; no request is taken
// until it ends, register writes are taken throughout.
`default_nettype none
module color_key_sprite_blitter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [11:0] req_pos_x,
   input  wire logic signed [11:0] req_pos_y,
   input  wire logic [9:0]         req_sprite_width,
   input  wire logic [9:0]         req_sprite_height,
   input  wire logic [31:0]        req_pixel_color,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_read_color,
   output logic                    rsp_read_outside,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [9:0]         csr_data
);
   import ckb_pkg::*;

   logic             accept;
   logic             csr_we;
   logic             push;
   logic             pop;
   logic             clearing;
   op_type           push_op;
   op_type           head_op;
   queue_status_type q_status;

   // request and register transfers
   assign busy      = q_status.full || clearing || csr_valid;
   assign accept    = start && !busy;
   assign csr_ready = q_status.empty;
   assign csr_we    = csr_valid && csr_ready;

   ckb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_type          (req_type),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .req_pixel_color   (req_pixel_color),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .push              (push),
      .push_op           (push_op)
   );

   ckb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (q_status)
   );

   ckb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_op          (head_op),
      .head_valid       (!q_status.empty),
      .csr_we           (csr_we),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_read_color   (rsp_read_color),
      .rsp_read_outside (rsp_read_outside)
   );

endmodule
`default_nettype wire

FILE: design/color_key_sprite_blitter_unit_checker.sv
`default_nettype none
`include "color_key_sprite_blitter_unit_assert.svh"
module color_key_sprite_blitter_unit_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic [31:0]        rsp_read_color,
   input wire logic               rsp_read_outside,
   input wire logic               csr_valid,
   input wire logic               csr_ready
);

   // an outside read carries a zero colour
   `CKB_ASSERT_SAME(a_outside_zero, clock, reset, rsp_valid && rsp_read_outside,
                    rsp_read_color == 32'd0, "outside read with nonzero colour")

   // the clearing sweep holds off requests right after reset
   `CKB_ASSERT_SAME(a_reset_sweep, clock, reset, $past(reset), busy,
                    "no clearing sweep after reset")

   // a register transfer starts a clearing sweep
   `CKB_ASSERT_NEXT(a_csr_sweep, clock, reset, csr_valid && csr_ready, busy,
                    "no clearing sweep after register write")

   // no read result follows a register transfer taken just as csr_ready rises
   `CKB_ASSERT_NEXT(a_csr_no_rsp, clock, reset,
                    csr_valid && csr_ready && !$past(csr_ready), !rsp_valid,
                    "read result overlaps register write")

endmodule

bind color_key_sprite_blitter_unit color_key_sprite_blitter_unit_checker u_checker (.*);
`default_nettype wire

FILE: tb/sv/color_key_sprite_blitter_unit_test.sv
`default_nettype none
module color_key_sprite_blitter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ckb_pkg::*;

   // one expected frame read
   typedef struct {
      logic [31:0] color;
      logic        outside;
   } frame_read_type;

   // shadow frame store and sprite walker, plus the queue of pending reads
   class blit_scoreboard;
      bit [31:0]        pixels [int];
      bit [9:0]         width_reg;
      bit [8:0]         height_reg;
      bit signed [11:0] org_x;
      bit signed [11:0] org_y;
      bit [9:0]         spr_w;
      bit [9:0]         spr_h;
      bit [9:0]         col_n;
      bit [9:0]         row_n;
      frame_read_type   pending_reads [$];
      int               failures;
      int               mismatches;
      int               reads_checked;

      function new();
         width_reg     = FRAME_WIDTH_RESET;
         height_reg    = FRAME_HEIGHT_RESET;
         org_x         = '0;
         org_y         = '0;
         spr_w         = '0;
         spr_h         = '0;
         col_n         = '0;
         row_n         = '0;
         failures      = 0;
         mismatches    = 0;
         reads_checked = 0;
      endfunction

      // oversized register values saturate at the store size
      function int vis_w();
         return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
      endfunction

      function int vis_h();
         return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
      endfunction

      function bit visible(int x, int y);
         return x >= 0 && y >= 0 && x < vis_w() && y < vis_h();
      endfunction

      // any register write resizes and wipes the frame
      function void write_register(logic idx, logic [9:0] value);
         if (idx == CSR_FRAME_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value[8:0];
         end
         pixels.delete();
      endfunction

      function void note_request(logic [1:0] kind, logic signed [11:0] x,
                                 logic signed [11:0] y, logic [9:0] w,
                                 logic [9:0] h, logic [31:0] color);
         int             px;
         int             py;
         frame_read_type rd;
         case (kind)
            REQ_HEADER: begin
               org_x = x;
               org_y = y;
               spr_w = w;
               spr_h = h;
               col_n = '0;
               row_n = '0;
            end
            REQ_PIXEL: begin
               // empty sprite, no header yet or past the last row
               if (spr_w == 0 || spr_h == 0 || row_n >= spr_h) return;
               px = int'(org_x) + int'(col_n);
               py = int'(org_y) + int'(row_n);
               if (color != COLOR_KEY && visible(px, py)) begin
                  pixels[py * MAX_WIDTH + px] = color;
               end
               col_n++;
               if (col_n >= spr_w) begin
                  col_n = '0;
                  row_n++;
               end
            end
            REQ_READ: begin
               px = int'(x);
               py = int'(y);
               if (visible(px, py)) begin
                  rd.color   = pixels.exists(py * MAX_WIDTH + px) ?
                               pixels[py * MAX_WIDTH + px] : '0;
                  rd.outside = 1'b0;
               end else begin
                  rd.color   = '0;
                  rd.outside = 1'b1;
               end
               pending_reads.push_back(rd);
            end
            default: begin
               pixels.delete();
            end
         endcase
      endfunction

      function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
         failures++;
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
         end
      endfunction

      function void check_read(logic [31:0] color, logic outside);
         frame_read_type rd;
         if (pending_reads.size() == 0) begin
            report("unexpected read result", '0, color);
            return;
         end
         rd = pending_reads.pop_front();
         reads_checked++;
         if (color !== rd.color) report("read_color", rd.color, color);
         if (outside !== rd.outside) report("read_outside", 32'(rd.outside), 32'(outside));
      endfunction
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic [1:0]  req_type          = REQ_HEADER;
   logic [11:0] req_pos_x         = '0;
   logic [11:0] req_pos_y         = '0;
   logic [9:0]  req_sprite_width  = '0;
   logic [9:0]  req_sprite_height = '0;
   logic [31:0] req_pixel_color   = '0;
   logic        csr_valid         = 1'b0;
   logic        csr_index         = CSR_FRAME_WIDTH;
   logic [9:0]  csr_data          = '0;
   logic        busy;
   logic        rsp_valid;
   logic [31:0] rsp_read_color;
   logic        rsp_read_outside;
   logic        csr_ready;

   blit_scoreboard board;
   int             idle_pct;
   int             items_sent;
   int             settings_used;

   color_key_sprite_blitter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_sprite_width  (req_sprite_width),
      .req_sprite_height (req_sprite_height),
      .req_pixel_color   (req_pixel_color),
      .rsp_valid         (rsp_valid),
      .rsp_read_color    (rsp_read_color),
      .rsp_read_outside  (rsp_read_outside),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // read results are taken on the edge that ends their cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_read(rsp_read_color, rsp_read_outside);
      end
   end

   // one request transfer, with random idle cycles in front of it
   task automatic issue(input logic [1:0] kind, input logic signed [11:0] x,
                        input logic signed [11:0] y, input logic [9:0] w,
                        input logic [9:0] h, input logic [31:0] color);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start             <= 1'b1;
      req_type          <= kind;
      req_pos_x         <= x;
      req_pos_y         <= y;
      req_sprite_width  <= w;
      req_sprite_height <= h;
      req_pixel_color   <= color;
      do @(posedge clock); while (busy);
      board.note_request(kind, x, y, w, h, color);
      items_sent++;
   endtask

   // unused fields carry junk
   task automatic send_header(input int x, input int y, input int w, input int h);
      issue(REQ_HEADER, 12'(x), 12'(y), 10'(w), 10'(h), $urandom);
   endtask

   task automatic send_pixel(input logic [31:0] color);
      issue(REQ_PIXEL, 12'($urandom), 12'($urandom), 10'($urandom), 10'($urandom), color);
   endtask

   task automatic send_read(input int x, input int y);
      issue(REQ_READ, 12'(x), 12'(y), 10'($urandom), 10'($urandom), $urandom);
   endtask

   // stop requesting and let every read and queued write come out
   task automatic drain();
      start <= 1'b0;
      while (board.pending_reads.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // register transfer on the csr channel
   task automatic write_csr(input logic idx, input logic [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.write_register(idx, value);
      settings_used++;
   endtask

   // a quarter of the colours are the key
   function automatic logic [31:0] random_color();
      return ($urandom_range(3) == 0) ? COLOR_KEY : 32'($urandom);
   endfunction

   // mostly well-formed sprites with reads over them, the rest noise
   task automatic run_random(input int count);
      int done_at;
      int pick;
      int ox;
      int oy;
      int sw;
      int sh;
      int n;
      done_at = items_sent + count;
      while (items_sent < done_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            sw = $urandom_range(1, 10);
            sh = $urandom_range(1, 6);
            ox = int'($urandom_range(0, board.vis_w() + 12)) - 8;
            oy = int'($urandom_range(0, board.vis_h() + 8)) - 6;
            send_header(ox, oy, sw, sh);
            n = sw * sh;
            pick = $urandom_range(9);
            // cut short or run past the last row now and then
            if (pick == 0) n = $urandom_range(0, n - 1);
            else if (pick == 1) n = n + $urandom_range(1, 4);
            repeat (n) send_pixel(random_color());
            repeat ($urandom_range(1, 4)) begin
               send_read(ox + int'($urandom_range(0, sw + 1)) - 1,
                         oy + int'($urandom_range(0, sh + 1)) - 1);
            end
         end else if (pick < 85) begin
            if ($urandom_range(1) == 0) begin
               send_read($urandom, $urandom);
            end else begin
               send_read($urandom_range(0, board.vis_w() + 2),
                         $urandom_range(0, board.vis_h() + 2));
            end
         end else if (pick < 95) begin
            send_header($urandom, $urandom, $urandom, $urandom);
            repeat ($urandom_range(0, 4)) send_pixel($urandom);
         end else begin
            repeat ($urandom_range(1, 3)) send_pixel($urandom);
         end
      end
   endtask

   // run limit
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int waited;
      board         = new();
      idle_pct      = 0;
      items_sent    = 0;
      settings_used = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: pixel before any header is dropped
      send_pixel(32'hAAAA5555);
      // sprite over the bottom right corner, key inside, one pixel too many
      send_header(318, 222, 3, 2);
      send_pixel(32'hFFFFFFFF);
      send_pixel(COLOR_KEY);
      send_pixel(32'h80000000);
      send_pixel(32'h00000001);
      send_pixel(32'h7FFFFFFF);
      send_pixel(32'hDEADBEEF);
      send_pixel(32'hCAFEF00D);
      send_read(318, 222);
      send_read(319, 222);
      send_read(320, 222);
      send_read(2047, 2047);
      send_read(-2048, -2048);
      // negative origin, only the last pixel lands
      send_header(-1, -1, 2, 2);
      send_pixel(32'h11111111);
      send_pixel(32'h22222222);
      send_pixel(32'h33333333);
      send_pixel(32'h44444444);
      // empty sprite drops its pixels
      send_header(0, 0, 0, 5);
      send_pixel(32'h55555555);
      // key over a stored pixel leaves it alone
      send_header(0, 0, 1, 1);
      send_pixel(COLOR_KEY);
      send_read(0, 0);
      issue(REQ_CLEAR, 12'($urandom), 12'($urandom), 10'($urandom), 10'($urandom),
            $urandom);
      send_read(318, 222);

      run_random(220);
      // oversized width, then oversized height, then the small corners
      drain();
      write_csr(CSR_FRAME_WIDTH, 10'd1023);
      idle_pct = 73;
      run_random(220);
      drain();
      write_csr(CSR_FRAME_HEIGHT, 10'd511);
      idle_pct = 12;
      run_random(220);
      drain();
      write_csr(CSR_FRAME_WIDTH, 10'd1);
      idle_pct = 0;
      run_random(220);
      drain();
      write_csr(CSR_FRAME_HEIGHT, 10'd1);
      idle_pct = 73;
      run_random(220);
      // zero width: nothing visible
      drain();
      write_csr(CSR_FRAME_WIDTH, 10'd0);
      idle_pct = 12;
      run_random(220);

      // wait out the tail, bounded
      start <= 1'b0;
      waited = 0;
      while (board.pending_reads.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (board.pending_reads.size() != 0) begin
         $display("%0d frame reads never answered", board.pending_reads.size());
         board.failures += board.pending_reads.size();
      end

      $display("covered %0d requests over %0d frame sizes, %0d reads checked",
               items_sent, settings_used, board.reads_checked);
      $display("mismatches: %0d", board.mismatches);
      if (board.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+design
design/ckb_pkg.sv
design/ckb_front.sv
design/ckb_queue.sv
design/ckb_back.sv
design/color_key_sprite_blitter_unit.sv
design/color_key_sprite_blitter_unit_checker.sv
tb/sv/color_key_sprite_blitter_unit_test.sv
